[rtl/core/lcg_pkg.sv]
// Package for the LCG random generator: request codes, generator constants,
// payload structs and the controller/datapath command and status structs.
// No dependencies.
`default_nettype none

package lcg_pkg;

    localparam int WordW = 32;

    localparam logic [1:0] REQ_RESEED = 2'd0;
    localparam logic [1:0] REQ_RAW    = 2'd1;
    localparam logic [1:0] REQ_RANGED = 2'd2;

    localparam logic [WordW-1:0] LCG_MUL     = 32'd1103515245;
    localparam logic [WordW-1:0] LCG_ADD     = 32'd12345;
    localparam logic [WordW-1:0] LCG_MODULUS = 32'd2147483647;
    localparam logic [WordW-1:0] WORD_RESET  = 32'd1;
    localparam logic [WordW-1:0] HALF_RANGE  = 32'h8000_0000;

    localparam int StepCount = WordW;
    localparam int StepW     = $clog2(StepCount);

    typedef struct packed {
        logic [1:0]              req_type;
        logic [WordW-1:0]        seed_value;
        logic signed [WordW-1:0] range_low;
        logic signed [WordW-1:0] range_high;
    } lcg_in_t;

    typedef struct packed {
        logic signed [WordW-1:0] random_value;
        logic                    range_error;
    } lcg_out_t;

    typedef struct packed {
        logic load;
        logic reseed;
        logic advance;
        logic reduce;
        logic div_step;
        logic finish;
    } lcg_cmd_t;

    typedef struct packed {
        logic raw;
        logic span_zero;
        logic div_last;
    } lcg_sts_t;

endpackage

`default_nettype wire

[rtl/core/lcg_ctrl.sv]
// Controller state machine for the LCG random generator.
// Depends on lcg_pkg; drives the datapath through lcg_cmd_t.
`default_nettype none

module lcg_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    input  wire logic [1:0]        s_req,
    output logic                   s_ready,
    output logic                   m_valid,
    input  wire logic              m_ready,
    input  wire lcg_pkg::lcg_sts_t sts,
    output lcg_pkg::lcg_cmd_t      cmd
);
    import lcg_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ADV  = 3'd1;
    localparam logic [2:0] ST_RED  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_req)
                        REQ_RESEED: cmd.reseed = 1'b1;
                        REQ_RAW, REQ_RANGED: begin
                            cmd.load   = 1'b1;
                            state_next = ST_ADV;
                        end
                        default: ;
                    endcase
                end
            end
            ST_ADV: begin
                cmd.advance = 1'b1;
                state_next  = ST_RED;
            end
            ST_RED: begin
                cmd.reduce = 1'b1;
                state_next = (sts.raw || sts.span_zero) ? ST_FIN : ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.finish   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/lcg_dp.sv]
// Datapath for the LCG random generator: generator word, multiplier,
// Mersenne reduction, radix-2 restoring remainder unit and result register.
// Depends on lcg_pkg; driven by lcg_ctrl through lcg_cmd_t.
`default_nettype none

module lcg_dp (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire lcg_pkg::lcg_in_t  s_data,
    input  wire lcg_pkg::lcg_cmd_t cmd,
    output lcg_pkg::lcg_sts_t      sts,
    output lcg_pkg::lcg_out_t      m_data
);
    import lcg_pkg::*;

    lcg_in_t          item_reg;
    lcg_out_t         out_reg;
    logic [WordW-1:0] word_reg;
    logic [WordW-1:0] value_reg;
    logic [WordW-1:0] dvd_reg;
    logic [WordW-1:0] rem_reg;
    logic [WordW-1:0] mag_reg;
    logic [StepW-1:0] cnt_reg;

    logic [WordW-1:0] span;
    logic [WordW-1:0] mag;
    logic [WordW-1:0] fold;
    logic [WordW-1:0] reduced;
    logic [WordW-1:0] trial;
    logic [WordW-1:0] ranged;

    // span = high - low + 1, wrapping; magnitude of the signed span
    assign span = WordW'(item_reg.range_high) - WordW'(item_reg.range_low) + WordW'(1);
    assign mag  = span[WordW-1] ? ((span == HALF_RANGE) ? HALF_RANGE : (~span + WordW'(1)))
                                : span;

    // x mod (2^31 - 1): fold the top bit back in, then one correction
    assign fold    = {1'b0, word_reg[WordW-2:0]} + WordW'(word_reg[WordW-1]);
    assign reduced = (fold >= LCG_MODULUS) ? (fold - LCG_MODULUS) : fold;

    assign trial  = {rem_reg[WordW-2:0], dvd_reg[WordW-1]};
    assign ranged = rem_reg + WordW'(item_reg.range_low);

    assign sts.raw       = (item_reg.req_type == REQ_RAW);
    assign sts.span_zero = (span == '0);
    assign sts.div_last  = (cnt_reg == StepW'(StepCount - 1));

    assign m_data = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_reg <= WORD_RESET;
        end else if (cmd.reseed) begin
            word_reg <= s_data.seed_value;
        end else if (cmd.advance) begin
            word_reg <= word_reg * LCG_MUL + LCG_ADD;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg <= s_data;
        end
        if (cmd.reduce) begin
            value_reg <= reduced;
            dvd_reg   <= reduced;
            rem_reg   <= '0;
            mag_reg   <= mag;
            cnt_reg   <= '0;
        end else if (cmd.div_step) begin
            rem_reg <= (trial >= mag_reg) ? (trial - mag_reg) : trial;
            dvd_reg <= {dvd_reg[WordW-2:0], 1'b0};
            cnt_reg <= cnt_reg + StepW'(1);
        end
        if (cmd.finish) begin
            if (sts.raw) begin
                out_reg.random_value <= value_reg;
                out_reg.range_error  <= 1'b0;
            end else if (sts.span_zero) begin
                out_reg.random_value <= '0;
                out_reg.range_error  <= 1'b1;
            end else begin
                out_reg.random_value <= ranged;
                out_reg.range_error  <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/core/lcg_random_with_range.sv]
// Top level of the LCG random generator with ranged draws.
// Depends on lcg_pkg, lcg_ctrl and lcg_dp.
//
// Input channel s_*: one request per transfer. Reseed loads the generator
// word in the transfer cycle and gives no result; code 3 is dropped.
// Raw and ranged draws advance the word (word * 1103515245 + 12345) and
// give one result on m_*.
// After the input transfer a draw passes the advance, reduce and finish
// steps; a ranged draw with a nonzero span also passes the 32-step
// restoring remainder unit (one quotient bit per cycle) before finishing.
// One draw in flight; s_ready is high only while idle, so the next draw is
// taken only after the last one has finished.
// Reset (aresetn low, synchronous) sets the generator word to 1 and
// empties the result register.
// Stalls: the result register holds while m_ready is low; a finished draw
// waits in its last step until the register frees, and the input side
// takes reseeds and the next draw while a result waits, but not while a draw waits in its last step.
`default_nettype none

module lcg_random_with_range (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire lcg_pkg::lcg_in_t s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output lcg_pkg::lcg_out_t     m_data
);
    import lcg_pkg::*;

    lcg_cmd_t cmd;
    lcg_sts_t sts;

    lcg_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_req   (s_data.req_type),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    lcg_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_data  (m_data)
    );

    a_draw_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.req_type == REQ_RAW || s_data.req_type == REQ_RANGED)
        |=> !s_ready)
        else $error("draw transfer did not make the block busy");

    a_reseed_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.req_type == REQ_RESEED |=> s_ready)
        else $error("reseed transfer left the block busy");

    a_valid_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(cmd.finish))
        else $error("result appeared without a finish step");

    a_finish_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> !s_ready)
        else $error("finish step while idle");

endmodule

`default_nettype wire

[test/lcg_random_with_range_tb.sv]
`timescale 1ns / 1ps
// Testbench for lcg_random_with_range: directed table, then random requests,
// with an in-bench generator model, or the table's result for typed rows, checking every result transfer.
// Depends on lcg_pkg and the lcg_random_with_range top level.

module lcg_random_with_range_tb;
    import lcg_pkg::*;

    localparam logic [1:0]  REQ_UNUSED   = 2'd3;
    localparam logic [31:0] GEN_MULT     = 32'd1103515245;
    localparam logic [31:0] GEN_INC      = 32'd12345;
    localparam logic [31:0] GEN_MOD      = 32'd2147483647;
    localparam int          RANDOM_DRAWS = 700;
    localparam int          QUIET_TAIL   = 100;
    localparam int          DRAIN_CYCLES = 60;
    localparam int          CYCLE_LIMIT  = 400000;

    typedef struct {
        lcg_in_t  req;
        bit       typed;
        lcg_out_t res;
    } dir_row_t;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    lcg_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    lcg_out_t m_data;

    bit       cur_typed     = 1'b0;
    lcg_out_t cur_typed_res = '0;

    dir_row_t    dir_table[$];
    lcg_out_t    expected_q[$];
    logic [31:0] gen_word = 32'd1;
    lcg_out_t    predicted;
    int          errors        = 0;
    int          cycle_count   = 0;
    int          stall_left    = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;

    lcg_random_with_range dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #2 aclk = ~aclk;

    // Result of a draw, given the generator word after it has advanced.
    function automatic lcg_out_t draw_result(input lcg_in_t req, input logic [31:0] word);
        logic [31:0] value;
        logic [31:0] span;
        logic [31:0] mag;
        lcg_out_t    r;
        value = word % GEN_MOD;
        r.range_error = 1'b0;
        if (req.req_type == REQ_RAW) begin
            r.random_value = value;
        end else begin
            span = $unsigned(req.range_high) - $unsigned(req.range_low) + 32'd1;
            if (span == 32'd0) begin
                r.random_value = '0;
                r.range_error = 1'b1;
            end else begin
                mag = span[31] ? (32'd0 - span) : span;
                r.random_value = (value % mag) + $unsigned(req.range_low);
            end
        end
        return r;
    endfunction

    function automatic lcg_in_t random_req();
        lcg_in_t r;
        int      k;
        r.req_type   = REQ_RANGED;
        r.seed_value = $urandom;
        r.range_low  = $urandom;
        r.range_high = $urandom;
        k = $urandom_range(0, 99);
        if (k < 8) begin
            r.req_type = REQ_RESEED;
            case ($urandom_range(0, 5))
                0: r.seed_value = 32'd0;
                1: r.seed_value = 32'hFFFF_FFFF;
                default: ;
            endcase
        end else if (k < 12) begin
            r.req_type = REQ_UNUSED;
        end else if (k < 40) begin
            r.req_type = REQ_RAW;
        end else begin
            case ($urandom_range(0, 9))
                0: ;
                1: r.range_high = r.range_low - 32'sd1;
                2: r.range_high = r.range_low + 32'sh7FFF_FFFF;
                3: r.range_high = r.range_low;
                4: r.range_high = r.range_low - $signed($urandom_range(2, 1000));
                5: begin
                    r.range_low  = 32'sh7FFF_FFFF - $signed($urandom_range(0, 50));
                    r.range_high = r.range_low + $signed($urandom_range(1, 1000));
                end
                default: r.range_high = r.range_low + $signed($urandom_range(1, 255));
            endcase
        end
        return r;
    endfunction

    task automatic add_row(input logic [1:0] kind, input logic [31:0] seed,
                           input logic [31:0] lo, input logic [31:0] hi,
                           input bit typed, input logic [31:0] val, input bit err);
        dir_row_t row;
        row.req.req_type         = kind;
        row.req.seed_value       = seed;
        row.req.range_low        = lo;
        row.req.range_high       = hi;
        row.typed                = typed;
        row.res.random_value     = val;
        row.res.range_error      = err;
        dir_table.push_back(row);
    endtask

    // Present one request; return at the edge of its transfer.
    task automatic send_req(input lcg_in_t req, input bit typed, input lcg_out_t res);
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_data        <= req;
        cur_typed     <= typed;
        cur_typed_res <= res;
        do @(posedge aclk); while (!(s_valid && s_ready));
    endtask

    always @(posedge aclk) begin
        cycle_count++;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                if (s_data.req_type == REQ_RESEED) begin
                    gen_word = s_data.seed_value;
                end else if (s_data.req_type != REQ_UNUSED) begin
                    gen_word = gen_word * GEN_MULT + GEN_INC;
                    predicted = cur_typed ? cur_typed_res : draw_result(s_data, gen_word);
                    expected_q.push_back(predicted);
                end
            end
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result transfer, actual %0d/%0b", $time,
                             m_data.random_value, m_data.range_error);
                end else begin
                    predicted = expected_q.pop_front();
                    if (m_data.random_value !== predicted.random_value) begin
                        errors++;
                        $display("%0t: random_value expected %0d actual %0d", $time,
                                 predicted.random_value, m_data.random_value);
                    end
                    if (m_data.range_error !== predicted.range_error) begin
                        errors++;
                        $display("%0t: range_error expected %0b actual %0b", $time,
                                 predicted.range_error, m_data.range_error);
                    end
                end
            end
        end
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else if (recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct) begin
            m_ready <= 1'b0;
            stall_left = $urandom_range(1, 13) - 1;
        end else begin
            m_ready <= 1'b1;
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        lcg_in_t req;
        int      draws;

        add_row(REQ_RAW,    32'h1234_5678, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 1, 32'd1103527590, 0);
        add_row(REQ_RANGED, 32'h0,         32'h0,         32'hFFFF_FFFF, 1, 32'd0, 1);
        add_row(REQ_RANGED, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1, 32'd0, 1);
        add_row(REQ_RANGED, 32'h0,         32'd5,         32'd4,         1, 32'd0, 1);
        add_row(REQ_UNUSED, 32'hDEAD_BEEF, 32'h1,         32'h2,         0, 32'd0, 0);
        add_row(REQ_RAW,    32'h0,         32'h0,         32'h0,         0, 32'd0, 0);
        add_row(REQ_RANGED, 32'h0,         32'h0,         32'h7FFF_FFFF, 0, 32'd0, 0);
        add_row(REQ_RANGED, 32'h0,         32'h8000_0000, 32'hFFFF_FFFF, 0, 32'd0, 0);
        add_row(REQ_RANGED, 32'h0,         32'h8000_0000, 32'h8000_0000, 1, 32'h8000_0000, 0);
        add_row(REQ_RANGED, 32'h0,         32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 0);
        add_row(REQ_RANGED, 32'h0,         32'h7FFF_FFFF, 32'h7FFF_FFF0, 0, 32'd0, 0);
        add_row(REQ_RANGED, 32'h0,         32'd100,       -32'sd100,     0, 32'd0, 0);
        add_row(REQ_RANGED, 32'h0,         -32'sd10,      32'd10,        0, 32'd0, 0);
        add_row(REQ_RESEED, 32'h0,         32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 32'd0, 0);
        add_row(REQ_RAW,    32'hFFFF_FFFF, 32'h0,         32'h0,         1, 32'd12345, 0);
        add_row(REQ_RESEED, 32'hFFFF_FFFF, 32'h0,         32'h0,         0, 32'd0, 0);
        add_row(REQ_RAW,    32'h0,         32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 32'd0, 0);
        add_row(REQ_RANGED, 32'h0,         32'd0,         -32'sd2,       0, 32'd0, 0);
        add_row(REQ_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 32'd0, 0);
        add_row(REQ_RANGED, 32'h0,         32'd1,         32'h8000_0000, 0, 32'd0, 0);
        add_row(REQ_RESEED, 32'hA5A5_A5A5, 32'h0,         32'h0,         0, 32'd0, 0);
        add_row(REQ_RANGED, 32'h5A5A_5A5A, -32'sd1000,    32'd1000,      0, 32'd0, 0);
        add_row(REQ_RAW,    32'h0,         32'h0,         32'h0,         0, 32'd0, 0);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 25;
        recv_idle_pct = 25;
        foreach (dir_table[i]) begin
            send_req(dir_table[i].req, dir_table[i].typed, dir_table[i].res);
        end

        draws = 0;
        while (draws < RANDOM_DRAWS) begin
            if (draws >= RANDOM_DRAWS - QUIET_TAIL) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end else if (draws % 100 == 0) begin
                case ($urandom_range(0, 2))
                    0: send_idle_pct = 0;
                    1: send_idle_pct = 15;
                    default: send_idle_pct = 50;
                endcase
                case ($urandom_range(0, 2))
                    0: recv_idle_pct = 0;
                    1: recv_idle_pct = 15;
                    default: recv_idle_pct = 50;
                endcase
            end
            req = random_req();
            if (req.req_type != REQ_UNUSED) draws++;
            send_req(req, 1'b0, '0);
        end
        s_valid <= 1'b0;

        while (expected_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[files.f]
rtl/core/lcg_pkg.sv
rtl/core/lcg_ctrl.sv
rtl/core/lcg_dp.sv
rtl/core/lcg_random_with_range.sv
test/lcg_random_with_range_tb.sv
